### design/pfrc_pkg.sv
// Package for the PWM frequency range classifier.
// Holds widths, reset values, codes, the job record and the status classifier.
// No dependencies; every other design file imports it.
package pfrc_pkg;

   // Sizing of the datapath
   localparam int COUNT_WIDTH = 16;
   localparam int TIME_WIDTH  = 32;
   localparam int FRAC_BITS   = 8;

   localparam int LEVEL_W    = 16;
   localparam int REST_W     = 16;
   localparam int FREQ_W     = 24;
   localparam int CSR_DATA_W = 24;
   localparam int CSR_IDX_W  = 2;

   localparam int AVG_W = TIME_WIDTH + FRAC_BITS;
   localparam int CMP_W = (COUNT_WIDTH > REST_W) ? COUNT_WIDTH : REST_W;

   // Microseconds per second, and the bits it needs
   localparam int US_PER_S = 1000000;
   localparam int US_W     = 20;

   // Divider operand widths
   localparam int NUM_W     = COUNT_WIDTH + US_W + FRAC_BITS;
   localparam int AVG_LO_W  = AVG_W / 2;
   localparam int AVG_HI_W  = AVG_W - AVG_LO_W;
   localparam int PLO_W     = COUNT_WIDTH + AVG_LO_W;
   localparam int PHI_W     = COUNT_WIDTH + AVG_HI_W;
   localparam int DEN_W     = COUNT_WIDTH + AVG_W;
   localparam int DSH_W     = DEN_W + FREQ_W - 1;
   localparam int DIV_CNT_W = $clog2(FREQ_W);

   // Job queue between front and back
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam logic [FREQ_W-1:0] FREQ_MAX = '1;

   // Register reset values
   localparam logic [REST_W-1:0] RST_MAX_REST   = REST_W'(20);
   localparam logic [FREQ_W-1:0] RST_ERROR_HZ   = FREQ_W'(1200);
   localparam logic [FREQ_W-1:0] RST_FAR_HZ     = FREQ_W'(4500);
   localparam logic [FREQ_W-1:0] RST_NEAR_HZ    = FREQ_W'(7000);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_MAX_REST = 2'd0,
      CSR_ERROR_HZ = 2'd1,
      CSR_FAR_HZ   = 2'd2,
      CSR_NEAR_HZ  = 2'd3
   } csr_index_type;

   typedef enum logic [1:0] {
      ST_OUT_OF_RANGE = 2'd0,
      ST_ERROR        = 2'd1,
      ST_FAR          = 2'd2,
      ST_NEAR         = 2'd3
   } range_status_type;

   // What the back end does with the held frequency
   typedef enum logic [1:0] {
      JOB_HOLD,
      JOB_CLEAR,
      JOB_ESTIMATE
   } job_kind_type;

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_MUL_LO,
      BK_MUL_HI,
      BK_SUM,
      BK_CHECK,
      BK_DIVIDE,
      BK_DONE
   } back_state_type;

   typedef struct packed {
      job_kind_type             kind;
      logic                     idle;
      logic [COUNT_WIDTH-1:0]   edge_tally;
      logic [COUNT_WIDTH-1:0]   sample_tally;
      logic [AVG_W-1:0]         avg_period;
   } job_type;

   typedef struct packed {
      logic [FREQ_W-1:0] error_hz;
      logic [FREQ_W-1:0] far_hz;
      logic [FREQ_W-1:0] near_hz;
   } limits_type;

   // Range status of a frequency against the three limits
   function automatic range_status_type classify(input logic [FREQ_W-1:0] freq,
                                                 input logic              idle,
                                                 input limits_type        lim);
      range_status_type st;
      priority if (idle) begin
         st = ST_OUT_OF_RANGE;
      end else if (freq <= lim.error_hz) begin
         st = ST_ERROR;
      end else if (freq <= lim.far_hz) begin
         st = ST_FAR;
      end else if (freq <= lim.near_hz) begin
         st = ST_NEAR;
      end else begin
         st = ST_ERROR;
      end
      return st;
   endfunction

endpackage

### design/pfrc_channels.sv
// Handshake channels of the PWM frequency range classifier.
// Sample transactions in, status transactions out; depends on pfrc_pkg.
interface pfrc_req_if;
   import pfrc_pkg::*;

   logic                  valid;
   logic                  ready;
   logic [TIME_WIDTH-1:0] sample_time_us;
   logic [LEVEL_W-1:0]    sample_level;

   modport source (output valid, output sample_time_us, output sample_level, input ready);
   modport sink   (input valid, input sample_time_us, input sample_level, output ready);
endinterface

interface pfrc_rsp_if;
   import pfrc_pkg::*;

   logic              valid;
   logic              ready;
   logic [1:0]        range_status;
   logic [FREQ_W-1:0] freq_hz;

   modport source (output valid, output range_status, output freq_hz, input ready);
   modport sink   (input valid, input range_status, input freq_hz, output ready);
endinterface

### design/pfrc_front.sv
// Front end: accepts sample transactions, updates period average and tallies,
// and queues one job per sample for the back end. Depends on pfrc_pkg and pfrc_channels.
module pfrc_front (
   input  logic                        clock,
   input  logic                        reset,
   pfrc_req_if.sink                    req_if,
   input  logic [pfrc_pkg::REST_W-1:0] max_rest_count,
   input  logic                        q_full,
   output logic                        q_push,
   output pfrc_pkg::job_type           q_job
);
   import pfrc_pkg::*;

   logic [TIME_WIDTH-1:0]  prev_time_ff,  prev_time_in;
   logic [LEVEL_W-1:0]     prev_level_ff, prev_level_in;
   logic [AVG_W-1:0]       avg_ff,        avg_in;
   logic [COUNT_WIDTH-1:0] sample_ff,     sample_in;
   logic [COUNT_WIDTH-1:0] edge_ff,       edge_in;
   logic [COUNT_WIDTH-1:0] quiet_ff,      quiet_in;

   logic                   accept;
   logic [TIME_WIDTH-1:0]  diff;
   logic [AVG_W-1:0]       period;
   logic [AVG_W:0]         avg_sum;
   logic [COUNT_WIDTH-1:0] sample_inc, edge_inc, quiet_inc;
   logic                   level_change;
   job_kind_type           kind;

   assign req_if.ready = !q_full;
   assign accept       = req_if.valid && req_if.ready;
   assign q_push       = accept;

   // Period, running average and saturating tallies
   always_comb begin
      diff    = req_if.sample_time_us - prev_time_ff;
      period  = AVG_W'(diff) << FRAC_BITS;
      avg_sum = {1'b0, avg_ff} + {1'b0, period};
      avg_in  = (avg_ff == '0) ? period : avg_sum[AVG_W:1];

      sample_inc = (&sample_ff) ? sample_ff : sample_ff + COUNT_WIDTH'(1);
      edge_inc   = (&edge_ff)   ? edge_ff   : edge_ff   + COUNT_WIDTH'(1);
      quiet_inc  = (&quiet_ff)  ? quiet_ff  : quiet_ff  + COUNT_WIDTH'(1);

      level_change  = req_if.sample_level != prev_level_ff;
      prev_time_in  = req_if.sample_time_us;
      prev_level_in = req_if.sample_level;

      if (level_change) begin
         // count the edge unless it ends a long quiet zone
         edge_in   = (CMP_W'(quiet_ff) <= CMP_W'(max_rest_count)) ? edge_inc : edge_ff;
         quiet_in  = '0;
         sample_in = sample_inc;
         kind      = JOB_ESTIMATE;
      end else if (CMP_W'(quiet_inc) > CMP_W'(max_rest_count)) begin
         // close the burst
         edge_in   = '0;
         quiet_in  = quiet_inc - COUNT_WIDTH'(1);
         sample_in = '0;
         kind      = (edge_ff != '0) ? JOB_CLEAR : JOB_HOLD;
      end else begin
         edge_in   = edge_ff;
         quiet_in  = quiet_inc;
         sample_in = sample_inc;
         kind      = JOB_HOLD;
      end
   end

   // Job for the back end, built from the updated state
   always_comb begin
      q_job.kind         = kind;
      q_job.idle         = (sample_in == '0) && (edge_in == '0);
      q_job.edge_tally   = edge_in;
      q_job.sample_tally = sample_in;
      q_job.avg_period   = avg_in;
   end

   // Advance the state on each accepted transaction
   always_ff @(posedge clock) begin
      if (reset) begin
         prev_time_ff  <= '0;
         prev_level_ff <= '0;
         avg_ff        <= '0;
         sample_ff     <= '0;
         edge_ff       <= '0;
         quiet_ff      <= '0;
      end else if (accept) begin
         prev_time_ff  <= prev_time_in;
         prev_level_ff <= prev_level_in;
         avg_ff        <= avg_in;
         sample_ff     <= sample_in;
         edge_ff       <= edge_in;
         quiet_ff      <= quiet_in;
      end
   end

endmodule

### design/pfrc_job_queue.sv
// Short job queue between the front and back ends of the classifier.
// Register file of job records with read and write pointers; depends on pfrc_pkg.
module pfrc_job_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  pfrc_pkg::job_type push_job,
   output logic              full,
   input  logic              pop,
   output logic              head_valid,
   output pfrc_pkg::job_type head_job
);
   import pfrc_pkg::*;

   job_type             entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff,  count_in;
   logic                do_push, do_pop;

   assign full       = count_ff == QCNT_W'(QUEUE_DEPTH);
   assign head_valid = count_ff != '0;
   assign head_job   = entry_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   // Pointer and fill count update
   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + QPTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + QCNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the job at the write pointer
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

### design/pfrc_back.sv
// Back end: runs queued jobs, re-estimates frequency with a split multiply and
// a one-bit-per-cycle restoring divider, and holds the result register.
// Depends on pfrc_pkg and pfrc_channels.
module pfrc_back (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 q_valid,
   input  pfrc_pkg::job_type    q_job,
   output logic                 q_pop,
   input  pfrc_pkg::limits_type limits,
   pfrc_rsp_if.source           rsp_if
);
   import pfrc_pkg::*;

   back_state_type         state_ff, state_in;

   logic [FREQ_W-1:0]      freq_ff;
   logic                   rsp_valid_ff;
   range_status_type       rsp_status_ff;
   logic [FREQ_W-1:0]      rsp_freq_ff;

   logic                   idle_ff;
   logic [COUNT_WIDTH-1:0] edge_ff;
   logic [COUNT_WIDTH-1:0] sample_ff;
   logic [AVG_W-1:0]       avg_ff;
   logic [NUM_W-1:0]       num_ff;
   logic [PLO_W-1:0]       plo_ff;
   logic [PHI_W-1:0]       phi_ff;
   logic [DEN_W-1:0]       den_ff;
   logic [NUM_W-1:0]       rem_ff;
   logic [DSH_W-1:0]       dsh_ff;
   logic [FREQ_W-1:0]      quo_ff;
   logic [DIV_CNT_W-1:0]   cnt_ff;

   logic                   out_free;
   logic                   load_out;
   logic [FREQ_W-1:0]      out_freq;
   logic                   out_idle;
   logic                   den_zero;
   logic                   overflow;
   logic                   trial;
   logic                   div_last;

   assign out_free = !rsp_valid_ff || rsp_if.ready;
   assign den_zero = den_ff == '0;
   assign overflow = DEN_W'(num_ff[NUM_W-1:FREQ_W]) >= den_ff;
   assign trial    = DSH_W'(rem_ff) >= dsh_ff;
   assign div_last = cnt_ff == DIV_CNT_W'(FREQ_W - 1);

   assign rsp_if.valid        = rsp_valid_ff;
   assign rsp_if.range_status = rsp_status_ff;
   assign rsp_if.freq_hz      = rsp_freq_ff;

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         BK_IDLE: begin
            if (q_valid && q_job.kind == JOB_ESTIMATE) begin
               state_in = BK_MUL_LO;
            end
         end
         BK_MUL_LO: state_in = BK_MUL_HI;
         BK_MUL_HI: state_in = BK_SUM;
         BK_SUM:    state_in = BK_CHECK;
         BK_CHECK: begin
            state_in = (den_zero || overflow) ? BK_DONE : BK_DIVIDE;
         end
         BK_DIVIDE: begin
            if (div_last) begin
               state_in = BK_DONE;
            end
         end
         BK_DONE: begin
            if (out_free) begin
               state_in = BK_IDLE;
            end
         end
         default: state_in = BK_IDLE;
      endcase
   end

   // Queue pop and result load
   always_comb begin
      q_pop    = 1'b0;
      load_out = 1'b0;
      out_freq = freq_ff;
      out_idle = idle_ff;
      unique case (state_ff)
         BK_IDLE: begin
            if (q_valid) begin
               if (q_job.kind == JOB_ESTIMATE) begin
                  q_pop = 1'b1;
               end else if (out_free) begin
                  q_pop    = 1'b1;
                  load_out = 1'b1;
                  out_freq = (q_job.kind == JOB_CLEAR) ? '0 : freq_ff;
                  out_idle = q_job.idle;
               end
            end
         end
         BK_DONE: begin
            if (out_free) begin
               load_out = 1'b1;
               out_freq = quo_ff;
            end
         end
         default: begin
            q_pop    = 1'b0;
            load_out = 1'b0;
         end
      endcase
   end

   // Control registers: state, held frequency, result valid
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         freq_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (load_out) begin
            freq_ff      <= out_freq;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_if.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Result payload
   always_ff @(posedge clock) begin
      if (load_out) begin
         rsp_status_ff <= classify(out_freq, out_idle, limits);
         rsp_freq_ff   <= out_freq;
      end
   end

   // Estimate datapath: split multiply, denominator sum, then divide
   always_ff @(posedge clock) begin
      unique case (state_ff)
         BK_IDLE: begin
            if (q_pop) begin
               idle_ff   <= q_job.idle;
               edge_ff   <= q_job.edge_tally;
               sample_ff <= q_job.sample_tally;
               avg_ff    <= q_job.avg_period;
            end
         end
         BK_MUL_LO: begin
            num_ff <= NUM_W'(NUM_W'(edge_ff) * NUM_W'(US_PER_S)) << FRAC_BITS;
            plo_ff <= PLO_W'(sample_ff) * PLO_W'(avg_ff[AVG_LO_W-1:0]);
         end
         BK_MUL_HI: begin
            phi_ff <= PHI_W'(sample_ff) * PHI_W'(avg_ff[AVG_W-1:AVG_LO_W]);
         end
         BK_SUM: begin
            den_ff <= DEN_W'(plo_ff) + (DEN_W'(phi_ff) << AVG_LO_W);
         end
         BK_CHECK: begin
            rem_ff <= num_ff;
            dsh_ff <= DSH_W'(den_ff) << (FREQ_W - 1);
            cnt_ff <= '0;
            priority if (den_zero) begin
               quo_ff <= (edge_ff != '0) ? FREQ_MAX : '0;
            end else if (overflow) begin
               quo_ff <= FREQ_MAX;
            end else begin
               quo_ff <= '0;
            end
         end
         BK_DIVIDE: begin
            // one quotient bit per cycle
            if (trial) begin
               rem_ff <= rem_ff - dsh_ff[NUM_W-1:0];
            end
            dsh_ff <= dsh_ff >> 1;
            quo_ff <= {quo_ff[FREQ_W-2:0], trial};
            cnt_ff <= cnt_ff + DIV_CNT_W'(1);
         end
         BK_DONE: begin
            quo_ff <= quo_ff;
         end
         default: begin
            cnt_ff <= '0;
         end
      endcase
   end

endmodule

### design/pwm_frequency_range_classifier.sv
// PWM frequency range classifier: one status transaction per sample transaction.
// A sample with no level change is classified from the held or cleared frequency;
// one with a change runs the split multiply, sum and check and a restoring divider.
// Throughput: one transaction per cycle without changes, while results are not
// stalled; a 4-entry job queue lets samples enter while the divider runs.
// Synchronous active-high reset clears control state, restores register defaults.
module pwm_frequency_range_classifier (
   input  logic                            clock,
   input  logic                            reset,
   pfrc_req_if.sink                        req_if,
   pfrc_rsp_if.source                      rsp_if,
   input  logic                            csr_wr_en,
   input  pfrc_pkg::csr_index_type         csr_index,
   input  logic [pfrc_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import pfrc_pkg::*;

   logic [REST_W-1:0] max_rest_ff;
   limits_type        limits_ff;

   logic              q_full;
   logic              q_push;
   job_type           q_job_in;
   logic              q_pop;
   logic              q_valid;
   job_type           q_head;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         max_rest_ff        <= RST_MAX_REST;
         limits_ff.error_hz <= RST_ERROR_HZ;
         limits_ff.far_hz   <= RST_FAR_HZ;
         limits_ff.near_hz  <= RST_NEAR_HZ;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_MAX_REST: max_rest_ff        <= csr_wdata[REST_W-1:0];
            CSR_ERROR_HZ: limits_ff.error_hz <= csr_wdata[FREQ_W-1:0];
            CSR_FAR_HZ:   limits_ff.far_hz   <= csr_wdata[FREQ_W-1:0];
            CSR_NEAR_HZ:  limits_ff.near_hz  <= csr_wdata[FREQ_W-1:0];
            default:      max_rest_ff        <= max_rest_ff;
         endcase
      end
   end

   pfrc_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_if         (req_if),
      .max_rest_count (max_rest_ff),
      .q_full         (q_full),
      .q_push         (q_push),
      .q_job          (q_job_in)
   );

   pfrc_job_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_job   (q_job_in),
      .full       (q_full),
      .pop        (q_pop),
      .head_valid (q_valid),
      .head_job   (q_head)
   );

   pfrc_back u_back (
      .clock   (clock),
      .reset   (reset),
      .q_valid (q_valid),
      .q_job   (q_head),
      .q_pop   (q_pop),
      .limits  (limits_ff),
      .rsp_if  (rsp_if)
   );

endmodule

### design/pfrc_checker.sv
// Port-level checks on the result channel of the classifier, and the bind
// that attaches them to the top level. Depends on pfrc_pkg.
module pfrc_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        rsp_valid,
   input logic                        rsp_ready,
   input logic [1:0]                  range_status,
   input logic [pfrc_pkg::FREQ_W-1:0] freq_hz
);
   import pfrc_pkg::*;

   // Hold a stalled transaction
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result dropped while stalled");

   // Keep a stalled payload steady
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(freq_hz) && $stable(range_status))
      else $error("result payload changed while stalled");

   // No edges counted means no frequency
   a_idle_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && range_status == ST_OUT_OF_RANGE |-> freq_hz == '0)
      else $error("out-of-range status with nonzero frequency");

   // Drop any result on reset
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid straight after reset");

endmodule

bind pwm_frequency_range_classifier pfrc_checker u_pfrc_checker (
   .clock        (clock),
   .reset        (reset),
   .rsp_valid    (rsp_if.valid),
   .rsp_ready    (rsp_if.ready),
   .range_status (rsp_if.range_status),
   .freq_hz      (rsp_if.freq_hz)
);

### tb/sv/tb_pwm_frequency_range_classifier.sv
// Self-checking testbench for pwm_frequency_range_classifier: zero periods, timestamp wrap,
// burst closing, long quiet zones and random pulse trains over changing limits.
// Depends on pfrc_pkg and the pfrc_req_if / pfrc_rsp_if channel interfaces.
`timescale 1ns / 1ps

module tb_pwm_frequency_range_classifier;
   import pfrc_pkg::*;

   localparam int DRAIN_CYCLES = 40;

   typedef struct packed {
      range_status_type  status;
      logic [FREQ_W-1:0] freq;
   } status_rec_type;

   logic                  clock;
   logic                  reset;
   logic                  csr_wr_en;
   csr_index_type         csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   pfrc_req_if req_ch ();
   pfrc_rsp_if rsp_ch ();

   pwm_frequency_range_classifier i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_if    (req_ch.sink),
      .rsp_if    (rsp_ch.source),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // Meter copy: limits and running state
   logic [REST_W-1:0]      m_rest_limit;
   logic [FREQ_W-1:0]      m_error_hz;
   logic [FREQ_W-1:0]      m_far_hz;
   logic [FREQ_W-1:0]      m_near_hz;
   logic [TIME_WIDTH-1:0]  m_prev_time;
   logic [LEVEL_W-1:0]     m_prev_level;
   logic [AVG_W-1:0]       m_avg_period;
   logic [COUNT_WIDTH-1:0] m_samples;
   logic [COUNT_WIDTH-1:0] m_edges;
   logic [COUNT_WIDTH-1:0] m_quiet;
   logic [FREQ_W-1:0]      m_freq;

   status_rec_type pending_status[$];

   int unsigned mismatches;
   int unsigned results_checked;
   int unsigned samples_sent;
   int unsigned csr_writes;
   int unsigned stall_left;

   bit req_idling;
   bit rsp_idling;

   logic [TIME_WIDTH-1:0] stamp_us;
   logic [LEVEL_W-1:0]    cur_level;

   // Clock: 10 ns period
   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // Hard limit on the run
   initial begin
      #20_000_000;
      $display("pwm_frequency_range_classifier regression: fail");
      $finish;
   end

   function automatic logic [COUNT_WIDTH-1:0] tally_bump(input logic [COUNT_WIDTH-1:0] v);
      return (v == '1) ? v : v + 1'b1;
   endfunction

   // Edge rate in Hz: edges * 1e6 * 2^FRAC_BITS / (samples * avg period), saturated
   function automatic logic [FREQ_W-1:0] edge_rate_hz(input logic [COUNT_WIDTH-1:0] edges,
                                                      input logic [COUNT_WIDTH-1:0] samples,
                                                      input logic [AVG_W-1:0]       avg);
      logic [127:0] num;
      logic [127:0] den;
      logic [127:0] quo;
      num = (128'(edges) * 128'(US_PER_S)) << FRAC_BITS;
      den = 128'(samples) * 128'(avg);
      if (den == '0) begin
         return (edges != '0) ? FREQ_MAX : '0;
      end
      quo = num / den;
      if (quo > 128'(FREQ_MAX)) begin
         return FREQ_MAX;
      end
      return quo[FREQ_W-1:0];
   endfunction

   function automatic void meter_reset();
      m_rest_limit = RST_MAX_REST;
      m_error_hz   = RST_ERROR_HZ;
      m_far_hz     = RST_FAR_HZ;
      m_near_hz    = RST_NEAR_HZ;
      m_prev_time  = '0;
      m_prev_level = '0;
      m_avg_period = '0;
      m_samples    = '0;
      m_edges      = '0;
      m_quiet      = '0;
      m_freq       = '0;
   endfunction

   // Advance the meter by one sample and return the status it should report
   function automatic status_rec_type meter_step(input logic [TIME_WIDTH-1:0] t,
                                                 input logic [LEVEL_W-1:0]    lvl);
      logic [TIME_WIDTH-1:0] delta;
      logic [AVG_W-1:0]      period;
      logic [AVG_W:0]        sum;
      status_rec_type        r;
      delta  = t - m_prev_time;
      period = AVG_W'(delta) << FRAC_BITS;
      if (m_avg_period == '0) begin
         m_avg_period = period;
      end else begin
         sum          = {1'b0, m_avg_period} + {1'b0, period};
         m_avg_period = sum[AVG_W:1];
      end
      m_samples = tally_bump(m_samples);
      if (lvl != m_prev_level) begin
         // an edge after an over-long quiet zone is not counted
         if (m_quiet <= m_rest_limit) begin
            m_edges = tally_bump(m_edges);
         end
         m_quiet = '0;
         m_freq  = edge_rate_hz(m_edges, m_samples, m_avg_period);
      end else begin
         m_quiet = tally_bump(m_quiet);
      end
      // close the burst after too many quiet samples
      if (m_quiet > COUNT_WIDTH'(m_rest_limit)) begin
         if (m_edges != '0) begin
            m_edges = '0;
            m_freq  = '0;
         end
         m_quiet   = m_quiet - 1'b1;
         m_samples = '0;
      end
      m_prev_time  = t;
      m_prev_level = lvl;
      if (m_samples == '0 && m_edges == '0) begin
         r.status = ST_OUT_OF_RANGE;
      end else if (m_freq <= m_error_hz) begin
         r.status = ST_ERROR;
      end else if (m_freq <= m_far_hz) begin
         r.status = ST_FAR;
      end else if (m_freq <= m_near_hz) begin
         r.status = ST_NEAR;
      end else begin
         r.status = ST_ERROR;
      end
      r.freq = m_freq;
      return r;
   endfunction

   // Print one line per mismatch and count it
   task automatic report_mismatch(input string what, input longint unsigned got,
                                  input longint unsigned want);
      mismatches++;
      $display("MISMATCH %0s: got 0x%0h, expected 0x%0h (after %0d checked)",
               what, got, want, results_checked);
   endtask

   // Send one sample transaction, with an optional idle burst in front
   task automatic send_sample(input logic [TIME_WIDTH-1:0] t, input logic [LEVEL_W-1:0] lvl);
      @(negedge clock);
      if (req_idling && $urandom_range(0, 7) == 0) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 16)) @(negedge clock);
      end
      req_ch.valid          <= 1'b1;
      req_ch.sample_time_us <= t;
      req_ch.sample_level   <= lvl;
      do @(posedge clock); while (!req_ch.ready);
      pending_status = {pending_status, meter_step(t, lvl)};
      samples_sent++;
   endtask

   task automatic next_sample(input logic [TIME_WIDTH-1:0] delta_us,
                              input logic [LEVEL_W-1:0]    lvl);
      stamp_us  = stamp_us + delta_us;
      cur_level = lvl;
      send_sample(stamp_us, cur_level);
   endtask

   // Drop valid, then wait for every pending status and the back end to go quiet
   task automatic settle();
      @(negedge clock);
      req_ch.valid <= 1'b0;
      while (pending_status.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input csr_index_type idx, input logic [CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      case (idx)
         CSR_MAX_REST: m_rest_limit = value[REST_W-1:0];
         CSR_ERROR_HZ: m_error_hz   = value[FREQ_W-1:0];
         CSR_FAR_HZ:   m_far_hz     = value[FREQ_W-1:0];
         CSR_NEAR_HZ:  m_near_hz    = value[FREQ_W-1:0];
         default: ;
      endcase
      csr_writes++;
   endtask

   // Pick a register setting: defaults, extremes, ordered or scrambled limits
   task automatic pick_settings();
      logic [REST_W-1:0] rest;
      logic [FREQ_W-1:0] lim[3];
      logic [FREQ_W-1:0] swap;
      bit                ordered;
      ordered = 1'b1;
      case ($urandom_range(0, 5))
         0: begin
            rest = RST_MAX_REST;
            lim  = '{RST_ERROR_HZ, RST_FAR_HZ, RST_NEAR_HZ};
         end
         1: begin
            rest = '0;
            lim  = '{'0, '0, '0};
         end
         2: begin
            rest = '1;
            lim  = '{FREQ_MAX, FREQ_MAX, FREQ_MAX};
         end
         3: begin
            rest = REST_W'($urandom_range(1, 30));
            foreach (lim[i]) lim[i] = FREQ_W'($urandom_range(200, 20000));
         end
         4: begin
            rest    = REST_W'($urandom_range(0, 16'hFFFF));
            ordered = 1'b0;
            foreach (lim[i]) lim[i] = FREQ_W'($urandom_range(0, 24'hFFFFFF));
         end
         default: begin
            rest = REST_W'($urandom_range(0, 5));
            foreach (lim[i]) lim[i] = FREQ_W'($urandom_range(0, 24'hFFFFFF));
         end
      endcase
      // sort ascending unless scrambled limits are wanted
      if (ordered) begin
         for (int pass = 0; pass < 2; pass++) begin
            for (int i = 0; i < 2; i++) begin
               if (lim[i] > lim[i+1]) begin
                  swap     = lim[i];
                  lim[i]   = lim[i+1];
                  lim[i+1] = swap;
               end
            end
         end
      end
      write_csr(CSR_MAX_REST, CSR_DATA_W'(rest));
      write_csr(CSR_ERROR_HZ, lim[0]);
      write_csr(CSR_FAR_HZ, lim[1]);
      write_csr(CSR_NEAR_HZ, lim[2]);
   endtask

   // Response side: random stall bursts
   always @(negedge clock) begin
      if (stall_left != 0) begin
         stall_left   <= stall_left - 1;
         rsp_ch.ready <= 1'b0;
      end else if (rsp_idling && $urandom_range(0, 9) == 0) begin
         stall_left   <= $urandom_range(0, 15);
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= 1'b1;
      end
   end

   // Check each status transaction against the oldest pending one
   always @(posedge clock) begin
      status_rec_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (pending_status.size() == 0) begin
            report_mismatch("status with nothing pending", rsp_ch.freq_hz, 0);
         end else begin
            want = pending_status.pop_front();
            if (rsp_ch.range_status !== want.status) begin
               report_mismatch("range_status", rsp_ch.range_status, want.status);
            end
            if (rsp_ch.freq_hz !== want.freq) begin
               report_mismatch("freq_hz", rsp_ch.freq_hz, want.freq);
            end
            results_checked++;
         end
      end
   end

   // Zero period edge, full-scale levels, long gap and timestamp wrap
   task automatic test_zero_period_and_wrap();
      send_sample(32'd0, 16'h0000);
      send_sample(32'd0, 16'hFFFF);
      send_sample(32'd256, 16'h0000);
      send_sample(32'd512, 16'hFFFF);
      send_sample(32'd768, 16'h5555);
      send_sample(32'd1024, 16'hAAAA);
      send_sample(32'hFFFF_FF80, 16'hAAAA);
      send_sample(32'h0000_0010, 16'h0000);
      send_sample(32'h0000_0010, 16'h0000);
      stamp_us  = 32'h0000_0010;
      cur_level = 16'h0000;
   endtask

   // Burst closing at small limits, and an edge after a quiet zone beyond a lowered limit
   task automatic test_burst_close();
      settle();
      write_csr(CSR_MAX_REST, CSR_DATA_W'(2));
      next_sample(300, 16'h0001);
      repeat (3) next_sample(300, cur_level);
      next_sample(300, cur_level);
      next_sample(300, 16'h0002);
      settle();
      write_csr(CSR_MAX_REST, CSR_DATA_W'(0));
      next_sample(300, cur_level);
      next_sample(300, 16'h0003);
      next_sample(300, 16'h0004);
      settle();
      write_csr(CSR_MAX_REST, CSR_DATA_W'(5));
      repeat (4) next_sample(300, cur_level);
      settle();
      write_csr(CSR_MAX_REST, CSR_DATA_W'(1));
      next_sample(300, 16'h0005);
      settle();
      write_csr(CSR_MAX_REST, CSR_DATA_W'(RST_MAX_REST));
   endtask

   // Random pulse trains with quiet zones, mixed with noise segments
   task automatic test_random_traffic(input int unsigned n_items, input bit with_idling);
      int unsigned        sent;
      int unsigned        seg_len;
      int unsigned        period_us;
      int unsigned        toggle_pct;
      int unsigned        quiet_run;
      logic [LEVEL_W-1:0] lvl_a;
      logic [LEVEL_W-1:0] lvl_b;
      bit                 noisy;
      sent = 0;
      while (sent < n_items) begin
         settle();
         pick_settings();
         req_idling = with_idling && ($urandom_range(0, 2) != 0);
         rsp_idling = with_idling && ($urandom_range(0, 2) != 0);
         seg_len    = $urandom_range(20, 80);
         noisy      = ($urandom_range(0, 9) < 2);
         case ($urandom_range(0, 9))
            0, 1:       period_us = $urandom_range(1, 8);
            2, 3, 4, 5: period_us = $urandom_range(100, 1000);
            6, 7, 8:    period_us = $urandom_range(1000, 100000);
            default:    period_us = $urandom;
         endcase
         case ($urandom_range(0, 3))
            0:       toggle_pct = 100;
            1:       toggle_pct = 50;
            2:       toggle_pct = 20;
            default: toggle_pct = $urandom_range(5, 100);
         endcase
         lvl_a = LEVEL_W'($urandom_range(0, 16'hFFFF));
         lvl_b = LEVEL_W'($urandom_range(0, 16'hFFFF));
         repeat (seg_len) begin
            if (noisy) begin
               if ($urandom_range(0, 1) == 1) begin
                  stamp_us = $urandom;
               end else begin
                  stamp_us = stamp_us + $urandom_range(0, 3);
               end
               if ($urandom_range(0, 2) == 0) begin
                  cur_level = LEVEL_W'($urandom_range(0, 16'hFFFF));
               end
            end else begin
               stamp_us = stamp_us + period_us + $urandom_range(0, period_us / 8);
               if ($urandom_range(1, 100) <= toggle_pct) begin
                  cur_level = (cur_level == lvl_a) ? lvl_b : lvl_a;
               end
            end
            send_sample(stamp_us, cur_level);
            sent++;
            // now and then hold the level long enough to close the burst
            if (!noisy && $urandom_range(0, 24) == 0) begin
               quiet_run = (m_rest_limit < 40) ? m_rest_limit + $urandom_range(1, 3)
                                               : $urandom_range(1, 40);
               repeat (quiet_run) begin
                  next_sample(period_us, cur_level);
                  sent++;
               end
            end
         end
      end
   endtask

   // Hold the level over a long quiet zone with the largest rest limit
   task automatic test_long_quiet();
      settle();
      req_idling = 1'b0;
      rsp_idling = 1'b0;
      write_csr(CSR_MAX_REST, 24'h00FFFF);
      repeat (120) next_sample(150, cur_level);
      next_sample(150, cur_level ^ 16'h0101);
      next_sample(150, cur_level ^ 16'h8080);
      settle();
      write_csr(CSR_MAX_REST, CSR_DATA_W'(RST_MAX_REST));
      repeat (25) next_sample(150, cur_level);
   endtask

   initial begin
      reset                 = 1'b1;
      req_ch.valid          = 1'b0;
      req_ch.sample_time_us = '0;
      req_ch.sample_level   = '0;
      rsp_ch.ready          = 1'b0;
      csr_wr_en             = 1'b0;
      csr_index             = CSR_MAX_REST;
      csr_wdata             = '0;
      req_idling            = 1'b0;
      rsp_idling            = 1'b0;
      stall_left            = 0;
      stamp_us              = '0;
      cur_level             = '0;
      mismatches            = 0;
      results_checked       = 0;
      samples_sent          = 0;
      csr_writes            = 0;
      meter_reset();
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_zero_period_and_wrap();
      test_burst_close();
      test_random_traffic(1250, 1'b1);
      test_random_traffic(300, 1'b0);
      test_long_quiet();
      settle();

      if (pending_status.size() != 0) begin
         report_mismatch("statuses never delivered", pending_status.size(), 0);
      end
      $display("Sent %0d samples (directed, random trains, long quiet zone), %0d register writes",
               samples_sent, csr_writes);
      $display("Checked %0d status transactions, %0d mismatches", results_checked, mismatches);
      if (mismatches == 0) begin
         $display("pwm_frequency_range_classifier regression: pass");
      end else begin
         $display("pwm_frequency_range_classifier regression: fail");
      end
      $finish;
   end

endmodule
